// File: rtl/stmu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sparse tensor mode unfold index core.
package stmu_pkg;

  // Field widths fixed by the interface
  localparam int DIM_BITS      = 16;
  localparam int IDX_BITS      = 32;
  localparam int VALUE_BITS    = 32;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int NUM_DIMS      = 4;

  // Configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_MODE_COUNT  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_UNFOLD_MODE = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MODE_AS_ROW = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIM_SIZE0   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIM_SIZE1   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIM_SIZE2   = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DIM_SIZE3   = 3'd6;

  // Reset values
  localparam logic [2:0]          MODE_COUNT_RST = 3'd3;
  localparam logic [1:0]          UNFOLD_RST     = 2'd0;
  localparam logic                AS_ROW_RST     = 1'b1;
  localparam logic [DIM_BITS-1:0] DIM_RST        = 16'd1;

  // Decoded geometry handed from the register block to the datapath
  typedef struct packed {
    logic [2:0]          n;       // effective mode count
    logic [1:0]          mode;    // effective unfold mode
    logic                as_row;  // chosen mode drives the row index
    logic [1:0]          ord0;    // rotated mode in slot 0
    logic [1:0]          ord1;    // rotated mode in slot 1
    logic [1:0]          ord2;    // rotated mode in slot 2
    logic [DIM_BITS-1:0] dim1;    // size of the slot 1 mode
    logic [DIM_BITS-1:0] dim2;    // size of the slot 2 mode
  } geom_t;

endpackage

// File: rtl/stmu_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and decode of the rotated mode order.
module stmu_cfg #(
  parameter int MAX_MODES = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [stmu_pkg::CFG_ADDR_BITS-1:0]   cfg_index,
  input  logic [stmu_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output stmu_pkg::geom_t                      geom
);

  logic [2:0]                    mode_count;
  logic [1:0]                    unfold_mode;
  logic                          mode_as_row;
  logic [stmu_pkg::DIM_BITS-1:0] dim_size [stmu_pkg::NUM_DIMS];

  logic [2:0] n_eff;
  logic [1:0] m_eff;
  logic [2:0] t0, t1, t2;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_count  <= stmu_pkg::MODE_COUNT_RST;
      unfold_mode <= stmu_pkg::UNFOLD_RST;
      mode_as_row <= stmu_pkg::AS_ROW_RST;
      for (int i = 0; i < stmu_pkg::NUM_DIMS; i++) begin
        dim_size[i] <= stmu_pkg::DIM_RST;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        stmu_pkg::REG_MODE_COUNT:  mode_count  <= cfg_data[2:0];
        stmu_pkg::REG_UNFOLD_MODE: unfold_mode <= cfg_data[1:0];
        stmu_pkg::REG_MODE_AS_ROW: mode_as_row <= cfg_data[0];
        stmu_pkg::REG_DIM_SIZE0:   dim_size[0] <= cfg_data;
        stmu_pkg::REG_DIM_SIZE1:   dim_size[1] <= cfg_data;
        stmu_pkg::REG_DIM_SIZE2:   dim_size[2] <= cfg_data;
        stmu_pkg::REG_DIM_SIZE3:   dim_size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate mode count and unfold mode, then rotate the remaining modes
  always_comb begin
    if (mode_count < 3'd2) begin
      n_eff = 3'd2;
    end else if (mode_count > 3'(MAX_MODES)) begin
      n_eff = 3'(MAX_MODES);
    end else begin
      n_eff = mode_count;
    end
    if ({1'b0, unfold_mode} >= n_eff) begin
      m_eff = 2'(n_eff - 3'd1);
    end else begin
      m_eff = unfold_mode;
    end
    // (m + 1 + i) mod n; the sum stays below 2n for the active slots, one subtract is enough
    t0 = {1'b0, m_eff} + 3'd1;
    t1 = {1'b0, m_eff} + 3'd2;
    t2 = {1'b0, m_eff} + 3'd3;
    if (t0 >= n_eff) t0 = t0 - n_eff;
    if (t1 >= n_eff) t1 = t1 - n_eff;
    if (t2 >= n_eff) t2 = t2 - n_eff;
  end

  always_comb begin
    geom.n      = n_eff;
    geom.mode   = m_eff;
    geom.as_row = mode_as_row;
    geom.ord0   = t0[1:0];
    geom.ord1   = t1[1:0];
    geom.ord2   = t2[1:0];
    geom.dim1   = dim_size[t1[1:0]];
    geom.dim2   = dim_size[t2[1:0]];
  end

endmodule

// File: rtl/sparse_tensor_mode_unfold_index_core.sv
`timescale 1ns / 1ps
// Top level: mode-m unfolding index pipeline for sparse tensor nonzeros.
//
// Usage:
//   One nonzero per beat enters on in_valid/in_ready (coord0..coord3,
//   nonzero_value, in_last) and one result leaves on out_valid/out_ready
//   (row_index, col_index, out_value, out_last, index_overflow).
//   Configuration goes through cfg_write/cfg_index/cfg_data while no beat
//   is in flight; writes take effect on the next cycle.
//   Three register stages, the first loaded at the accept edge: stage 1
//   picks the rotated coordinates and forms the stride product, stage 2
//   does the coordinate-by-stride multiplies, stage 3 sums, flags overflow
//   and steers row/column into the output register.
//   Throughput is one beat per cycle while the output is not stalled.
//   When out_ready is low, valid bits collapse bubbles and in_ready drops
//   only once every stage holds a beat; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and restores the configuration
//   defaults (3 modes, mode 0, mode as row, all sizes 1).
module sparse_tensor_mode_unfold_index_core #(
  parameter int MAX_MODES  = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [stmu_pkg::CFG_ADDR_BITS-1:0]   cfg_index,
  input  logic [stmu_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [COORD_BITS-1:0]                coord0,
  input  logic [COORD_BITS-1:0]                coord1,
  input  logic [COORD_BITS-1:0]                coord2,
  input  logic [COORD_BITS-1:0]                coord3,
  input  logic [stmu_pkg::VALUE_BITS-1:0]      nonzero_value,
  input  logic                                 in_last,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [stmu_pkg::IDX_BITS-1:0]        row_index,
  output logic [stmu_pkg::IDX_BITS-1:0]        col_index,
  output logic [stmu_pkg::VALUE_BITS-1:0]      out_value,
  output logic                                 out_last,
  output logic                                 index_overflow
);

  localparam int IW     = stmu_pkg::IDX_BITS;
  localparam int DW     = stmu_pkg::DIM_BITS;
  localparam int T0_W   = COORD_BITS + IW;
  localparam int T1_W   = COORD_BITS + DW;
  localparam int SUM_W  = COORD_BITS + IW + 2;

  stmu_pkg::geom_t geom;

  stmu_cfg #(
    .MAX_MODES (MAX_MODES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // Handshake: each stage advances when empty or when the next one advances
  logic v1, v2;
  logic adv1, adv2, adv_o;

  assign adv_o    = !out_valid || out_ready;
  assign adv2     = !v2 || adv_o;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // Stage 1: coordinate selection and stride formation
  logic [COORD_BITS-1:0] coord_arr [stmu_pkg::NUM_DIMS];
  logic [IW-1:0]         dim_prod;
  logic [IW-1:0]         stride0_next;
  logic [DW-1:0]         stride1_next;
  logic                  stride2_next;

  logic [COORD_BITS-1:0]           s1_c0, s1_c1, s1_c2, s1_own;
  logic [IW-1:0]                   s1_stride0;
  logic [DW-1:0]                   s1_stride1;
  logic                            s1_stride2;
  logic [stmu_pkg::VALUE_BITS-1:0] s1_value;
  logic                            s1_last;

  assign coord_arr[0] = coord0;
  assign coord_arr[1] = coord1;
  assign coord_arr[2] = coord2;
  assign coord_arr[3] = coord3;
  assign dim_prod     = IW'(geom.dim1) * IW'(geom.dim2);

  // last active slot has stride 1; inactive slots get stride 0
  always_comb begin
    case (geom.n)
      3'd4: begin
        stride0_next = dim_prod;
        stride1_next = geom.dim2;
        stride2_next = 1'b1;
      end
      3'd3: begin
        stride0_next = IW'(geom.dim1);
        stride1_next = DW'(1);
        stride2_next = 1'b0;
      end
      default: begin
        stride0_next = IW'(1);
        stride1_next = '0;
        stride2_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_c0      <= coord_arr[geom.ord0];
      s1_c1      <= coord_arr[geom.ord1];
      s1_c2      <= coord_arr[geom.ord2];
      s1_own     <= coord_arr[geom.mode];
      s1_stride0 <= stride0_next;
      s1_stride1 <= stride1_next;
      s1_stride2 <= stride2_next;
      s1_value   <= nonzero_value;
      s1_last    <= in_last;
    end
  end

  // Stage 2: coordinate times stride
  logic [T0_W-1:0]                 s2_t0;
  logic [T1_W-1:0]                 s2_t1;
  logic [COORD_BITS-1:0]           s2_t2;
  logic [COORD_BITS-1:0]           s2_own;
  logic [stmu_pkg::VALUE_BITS-1:0] s2_value;
  logic                            s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      s2_t0    <= T0_W'(s1_c0) * T0_W'(s1_stride0);
      s2_t1    <= T1_W'(s1_c1) * T1_W'(s1_stride1);
      s2_t2    <= s1_stride2 ? s1_c2 : '0;
      s2_own   <= s1_own;
      s2_value <= s1_value;
      s2_last  <= s1_last;
    end
  end

  // Stage 3: sum, overflow flag and row/column steering
  logic [SUM_W-1:0] lin_sum;
  logic             lin_ovf;
  logic [IW-1:0]    own_ext;

  assign lin_sum = SUM_W'(s2_t0) + SUM_W'(s2_t1) + SUM_W'(s2_t2);
  assign lin_ovf = lin_sum[SUM_W-1:IW] != '0;
  assign own_ext = IW'(s2_own);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_o) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o && v2) begin
      if (geom.as_row) begin
        row_index <= own_ext;
        col_index <= lin_sum[IW-1:0];
      end else begin
        row_index <= lin_sum[IW-1:0];
        col_index <= own_ext;
      end
      out_value      <= s2_value;
      out_last       <= s2_last;
      index_overflow <= lin_ovf;
    end
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the sparse tensor mode unfold index core: directed table, then random phases.
module tb_top;
  import stmu_pkg::*;

  localparam int COORD_W         = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 10;
  localparam int BEATS_PER_PHASE = 75;
  localparam int DIRECTED_ROWS   = 20;
  localparam int DIRECTED_CFGS   = 9;
  localparam int MAX_WAIT        = 16;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 3'd7;  // unmapped index, writes ignored

  // one nonzero as it enters the core
  typedef struct packed {
    logic [NUM_DIMS-1:0][COORD_W-1:0] coord;
    logic [VALUE_BITS-1:0]            value;
    logic                             last;
  } nonzero_t;

  // one unfolded position as it leaves the core
  typedef struct packed {
    logic [IDX_BITS-1:0]   row;
    logic [IDX_BITS-1:0]   col;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  ovf;
  } position_t;

  typedef struct packed {
    logic [2:0]                        mode_count;
    logic [1:0]                        unfold_mode;
    logic                              as_row;
    logic [NUM_DIMS-1:0][DIM_BITS-1:0] dim;
  } unfold_cfg_t;

  // directed stimulus row; row/col/ovf only meaningful when typed is set
  typedef struct packed {
    logic [3:0]          cfg_sel;
    nonzero_t            nz;
    logic                typed;
    logic [IDX_BITS-1:0] row;
    logic [IDX_BITS-1:0] col;
    logic                ovf;
  } directed_row_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_ADDR_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [COORD_W-1:0]       coord0, coord1, coord2, coord3;
  logic [VALUE_BITS-1:0]    nonzero_value;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_ready;
  logic [IDX_BITS-1:0]      row_index;
  logic [IDX_BITS-1:0]      col_index;
  logic [VALUE_BITS-1:0]    out_value;
  logic                     out_last;
  logic                     index_overflow;

  position_t   pending_positions[$];
  unfold_cfg_t active_cfg;
  bit          steady;          // no idling on either side while set
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // configs: mode_count, unfold_mode, as_row, dim3, dim2, dim1, dim0
  unfold_cfg_t directed_cfgs [DIRECTED_CFGS] = '{
    {3'd3, 2'd0, 1'b1, 16'd1,     16'd1,     16'd1,     16'd1},     // reset values
    {3'd4, 2'd3, 1'b0, 16'hffff,  16'hffff,  16'hffff,  16'hffff},  // widest index
    {3'd0, 2'd3, 1'b1, 16'd9,     16'd8,     16'd7,     16'd6},     // count low, mode saturates
    {3'd7, 2'd1, 1'b1, 16'd0,     16'd7,     16'd0,     16'd5},     // count high, zero sizes
    {3'd2, 2'd0, 1'b0, 16'd1,     16'd1,     16'd200,   16'd100},
    {3'd1, 2'd2, 1'b0, 16'd6,     16'd5,     16'd4,     16'd3},
    {3'd3, 2'd3, 1'b0, 16'd6,     16'd5,     16'd4,     16'd3},
    {3'd4, 2'd2, 1'b1, 16'd0,     16'd0,     16'd0,     16'd0},
    {3'd4, 2'd0, 1'b1, 16'hffff,  16'hffff,  16'hffff,  16'hffff}
  };

  // sel, coord3, coord2, coord1, coord0, value, last, typed, row, col, ovf
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    {4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0,
     1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    {4'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff, 1'b1,
     1'b1, 32'h0000_ffff, 32'h0001_fffe, 1'b0},
    {4'd0, 16'ha5a5, 16'h8000, 16'h0001, 16'h1234, 32'h5a5a_5a5a, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'h8000_0001, 1'b1,
     1'b1, 32'h0001_ffff, 32'h0000_ffff, 1'b1},
    {4'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 32'h0000_0001, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd1, 16'hffff, 16'h0003, 16'h0002, 16'h0001, 32'h1357_9bdf, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0,
     1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    {4'd2, 16'h0004, 16'h0003, 16'h0002, 16'h0001, 32'h0000_00ff, 1'b1,
     1'b1, 32'h0000_0002, 32'h0000_0001, 1'b0},
    {4'd2, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 32'hdead_beef, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'h0f0f_0f0f, 1'b1,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd3, 16'h0004, 16'h0002, 16'h0001, 16'h0003, 32'hf0f0_f0f0, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd4, 16'h0009, 16'h0007, 16'h00fa, 16'h0096, 32'h3333_cccc, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd4, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 32'hcccc_3333, 1'b1,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd5, 16'h0028, 16'h001e, 16'h0014, 16'h000a, 32'h0000_0010, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd6, 16'h0028, 16'h001e, 16'h0014, 16'h000a, 32'h0000_0020, 1'b1,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd6, 16'h0005, 16'h0004, 16'h0003, 16'h0002, 32'h7fff_ffff, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'h8000_0000, 1'b1,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd8, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 32'h5555_aaaa, 1'b1,
     1'b1, 32'h0000_ffff, 32'h0001_ffff, 1'b1},
    {4'd8, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 32'haaaa_5555, 1'b0,
     1'b0, 32'h0, 32'h0, 1'b0},
    {4'd8, 16'h8000, 16'h8000, 16'h8000, 16'h0005, 32'h0123_4567, 1'b1,
     1'b0, 32'h0, 32'h0, 1'b0}
  };

  sparse_tensor_mode_unfold_index_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .coord0         (coord0),
    .coord1         (coord1),
    .coord2         (coord2),
    .coord3         (coord3),
    .nonzero_value  (nonzero_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .row_index      (row_index),
    .col_index      (col_index),
    .out_value      (out_value),
    .out_last       (out_last),
    .index_overflow (index_overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Position of a nonzero in the unfolded matrix under a given config
  function automatic position_t unfold_position(input nonzero_t nz, input unfold_cfg_t c);
    int unsigned n;
    int unsigned m;
    int unsigned k;
    int unsigned rot [NUM_DIMS];
    logic [63:0] stride [NUM_DIMS];
    logic [63:0] lin;
    logic [IDX_BITS-1:0] own;
    position_t p;
    n = c.mode_count;
    if (n < 2) n = 2;
    if (n > NUM_DIMS) n = NUM_DIMS;
    m = c.unfold_mode;
    if (m >= n) m = n - 1;
    // other modes in rotated order after the kept one
    for (int i = 0; i < n - 1; i++) rot[i] = (m + 1 + i) % n;
    // last rotated mode has stride 1; each earlier one scales by the next mode's size
    stride[n - 2] = 64'd1;
    for (k = n - 2; k > 0; k--) stride[k - 1] = stride[k] * c.dim[rot[k]];
    lin = 64'd0;
    for (int i = 0; i < n - 1; i++) lin = lin + nz.coord[rot[i]] * stride[i];
    own = IDX_BITS'(nz.coord[m]);
    p.ovf = |lin[63:32];
    p.row = c.as_row ? own : lin[31:0];
    p.col = c.as_row ? lin[31:0] : own;
    p.value = nz.value;
    p.last = nz.last;
    return p;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Program all registers once the pipe has drained; unused upper data bits are random
  task automatic load_unfold_cfg(input unfold_cfg_t c);
    logic [CFG_DATA_BITS-1:0] junk;
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    junk = CFG_DATA_BITS'($urandom);
    write_reg(REG_MODE_COUNT,  {junk[15:3], c.mode_count});
    write_reg(REG_UNFOLD_MODE, {junk[15:2], c.unfold_mode});
    write_reg(REG_MODE_AS_ROW, {junk[15:1], c.as_row});
    write_reg(REG_DIM_SIZE0,   c.dim[0]);
    write_reg(REG_DIM_SIZE1,   c.dim[1]);
    write_reg(REG_DIM_SIZE2,   c.dim[2]);
    write_reg(REG_DIM_SIZE3,   c.dim[3]);
    write_reg(REG_SPARE,       junk);
    cfg_write <= 1'b0;
    active_cfg = c;
  endtask

  // Offer one nonzero and log its expected position when the beat is taken
  task automatic send_nonzero(input nonzero_t nz, input bit typed, input position_t typed_pos);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    coord0        <= nz.coord[0];
    coord1        <= nz.coord[1];
    coord2        <= nz.coord[2];
    coord3        <= nz.coord[3];
    nonzero_value <= nz.value;
    in_last       <= nz.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_positions.push_back(typed ? typed_pos : unfold_position(nz, active_cfg));
  endtask

  function automatic unfold_cfg_t random_cfg();
    unfold_cfg_t c;
    c.mode_count  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(2, 4));
    c.unfold_mode = 2'($urandom_range(0, 3));
    c.as_row      = 1'($urandom_range(0, 1));
    for (int d = 0; d < NUM_DIMS; d++) begin
      case ($urandom_range(0, 5))
        0: c.dim[d] = '0;
        1: c.dim[d] = '1;
        2, 3: c.dim[d] = DIM_BITS'($urandom_range(1, 16));
        default: c.dim[d] = DIM_BITS'($urandom_range(1, 65535));
      endcase
    end
    return c;
  endfunction

  // Mostly in-range coordinates, with extremes and out-of-range ones mixed in
  function automatic nonzero_t random_nonzero(input unfold_cfg_t c);
    nonzero_t nz;
    for (int d = 0; d < NUM_DIMS; d++) begin
      case ($urandom_range(0, 5))
        0: nz.coord[d] = '0;
        1: nz.coord[d] = '1;
        2: nz.coord[d] = COORD_W'($urandom);
        default: nz.coord[d] = (c.dim[d] != 0) ? COORD_W'($urandom_range(0, c.dim[d] - 1))
                                               : COORD_W'($urandom);
      endcase
    end
    nz.value = $urandom;
    nz.last  = ($urandom_range(0, 7) == 0);
    return nz;
  endfunction

  // Output ready: random stall before each beat
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each output beat with the oldest expected position
  always @(posedge clk) begin
    position_t seen;
    position_t want;
    if (!rst && out_valid && out_ready) begin
      seen = {row_index, col_index, out_value, out_last, index_overflow};
      if (pending_positions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: row %h col %h value %h last %b ovf %b",
                   seen.row, seen.col, seen.value, seen.last, seen.ovf);
      end else begin
        want = pending_positions.pop_front();
        if (seen.row !== want.row || seen.col !== want.col || seen.value !== want.value ||
            seen.last !== want.last || seen.ovf !== want.ovf) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: row %h/%h col %h/%h value %h/%h last %b/%b ovf %b/%b (exp/got)",
                     want.row, seen.row, want.col, seen.col, want.value, seen.value,
                     want.last, seen.last, want.ovf, seen.ovf);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    logic [3:0]  cfg_now;
    unfold_cfg_t c;
    nonzero_t    nz;
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_MODE_COUNT;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    coord0        <= '0;
    coord1        <= '0;
    coord2        <= '0;
    coord3        <= '0;
    nonzero_value <= '0;
    in_last       <= 1'b0;
    active_cfg = directed_cfgs[0];
    cfg_now = 4'd0;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, first rows run on reset values
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_sel != cfg_now) begin
        cfg_now = directed_rows[i].cfg_sel;
        load_unfold_cfg(directed_cfgs[cfg_now]);
      end
      send_nonzero(directed_rows[i].nz, directed_rows[i].typed,
                   {directed_rows[i].row, directed_rows[i].col, directed_rows[i].nz.value,
                    directed_rows[i].nz.last, directed_rows[i].ovf});
    end

    // random phases: smallest geometry first, widest last
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c = random_cfg();
      if (ph == 0)
        c = {3'd2, 2'd0, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1};
      else if (ph == RANDOM_PHASES - 1)
        c = {3'd4, 2'd3, c.as_row, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
      steady = 1'b0;
      load_unfold_cfg(c);
      steady = ($urandom_range(0, 3) == 0);
      for (int b = 0; b < BEATS_PER_PHASE; b++) begin
        nz = random_nonzero(c);
        send_nonzero(nz, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // drain
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
